/* design/vcde_pkg.sv */
`default_nettype none
package vcde_pkg;
  localparam int CubeEdge = 8;
  localparam int CoordW = 3;
  localparam int RowCount = CubeEdge * CubeEdge;
  localparam int RowAddrW = 6;

  typedef enum logic [3:0] {
    OP_WRITE = 4'd0, OP_FLIP = 4'd1, OP_READ = 4'd2, OP_SET_PLANE = 4'd3,
    OP_CLR_PLANE = 4'd4, OP_SHIFT = 4'd5, OP_MIRROR = 4'd6, OP_FILL = 4'd7,
    OP_BOX_FILLED = 4'd8, OP_BOX_WALLS = 4'd9, OP_BOX_WIRE = 4'd10
  } op_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] axis;
    logic       flag;
    logic [2:0] x_a;
    logic [2:0] y_a;
    logic [2:0] z_a;
    logic [2:0] x_b;
    logic [2:0] y_b;
    logic [2:0] z_b;
    logic [2:0] plane_index;
    logic [7:0] pattern;
  } cmd_t;

  typedef struct packed {
    logic voxel_on;
    logic rejected;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;    // capture the command
    logic       clear;   // write zero to row idx during the clearing pass
    logic       single;  // read the voxel's row; write back or sample in the next cycle
    logic       sweep;   // read row idx for a whole-frame pass into the scratch frame
    logic       commit;  // read scratch row idx, copied to the frame in the next cycle
    logic [5:0] idx;
  } dp_cmd_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7-i];
    return r;
  endfunction

  function automatic logic [7:0] run_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) m[i] = (3'(i) >= lo) && (3'(i) <= hi);
    return m;
  endfunction
endpackage
`default_nettype wire

/* design/vcde_if.sv */
`default_nettype none
interface vcde_cmd_if;
  logic valid;
  logic ready;
  vcde_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vcde_res_if;
  logic valid;
  logic ready;
  vcde_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/voxel_cube_draw_engine.sv */
`default_nettype none
// Voxel cube draw engine: an 8x8x8 frame held as 64 rows, one drawing command per
// transaction and one result per command. After reset the block clears the frame,
// all 64 rows, one row per cycle, before it accepts its first command. Voxel write,
// flip and read offer their result after the SINGLE and FLUSH states (a registered
// row read, then the write back or voxel sample). Whole-frame commands (planes,
// shift, mirror, fill, boxes) offer their result after 64 row computations into a
// scratch frame, 64 row copies back and a FLUSH state to finish the last copy.
// Unknown ops and axis-none plane, shift and mirror commands offer their result
// in the cycle after acceptance. One command is in work at a time; the next is
// accepted no earlier than the cycle after the previous result transaction.
module voxel_cube_draw_engine (
  input wire logic clk,
  input wire logic rst_n,
  vcde_cmd_if.sink in_ch,
  vcde_res_if.source out_ch
);
  import vcde_pkg::*;

  dp_cmd_t dp_cmd;
  res_t res;

  vcde_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data.op), .in_axis(in_ch.data.axis),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .dp_cmd(dp_cmd)
  );

  vcde_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd_in(in_ch.data), .dp_cmd(dp_cmd), .res(res)
  );

  assign out_ch.data = res;
endmodule
`default_nettype wire

/* design/vcde_datapath.sv */
`default_nettype none
module vcde_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vcde_pkg::cmd_t   cmd_in,
  input  wire vcde_pkg::dp_cmd_t dp_cmd,
  output vcde_pkg::res_t        res
);
  import vcde_pkg::*;

  // Frame store and scratch copy for whole-frame passes. The frame is read at two
  // addresses a cycle (the row itself and, for shift and mirror, its source row)
  // into registers; the scratch frame is read at one address a cycle.
  logic [7:0] frame_r [RowCount];
  logic [7:0] tmp_r   [RowCount];
  cmd_t       cmd_r;
  logic       voxel_r;
  logic       rej_r;
  logic [7:0] row_a_r, row_b_r, tmp_q_r;
  logic [5:0] idx_d_r;
  logic       single_d_r, sweep_d_r, commit_d_r;

  logic [2:0] xl, xh, yl, yh, zl, zh, sy, sz, ry, rz;
  logic [7:0] run, ends, old_row, src_row, new_row, vbit;
  logic [5:0] addr_a, addr_b;
  logic in_y, in_z, by, bz;

  // Sorted box corners.
  assign xl = (cmd_r.x_a > cmd_r.x_b) ? cmd_r.x_b : cmd_r.x_a;
  assign xh = (cmd_r.x_a > cmd_r.x_b) ? cmd_r.x_a : cmd_r.x_b;
  assign yl = (cmd_r.y_a > cmd_r.y_b) ? cmd_r.y_b : cmd_r.y_a;
  assign yh = (cmd_r.y_a > cmd_r.y_b) ? cmd_r.y_a : cmd_r.y_b;
  assign zl = (cmd_r.z_a > cmd_r.z_b) ? cmd_r.z_b : cmd_r.z_a;
  assign zh = (cmd_r.z_a > cmd_r.z_b) ? cmd_r.z_a : cmd_r.z_b;
  assign run = run_mask(xl, xh);
  assign ends = (8'd1 << xl) | (8'd1 << xh);

  // Read stage addresses: the row being processed and its source row.
  assign rz = dp_cmd.idx[5:3];
  assign ry = dp_cmd.idx[2:0];

  always_comb begin
    addr_a = dp_cmd.single ? {cmd_r.z_a, cmd_r.y_a} : dp_cmd.idx;
    addr_b = dp_cmd.idx;
    case (cmd_r.op)
      OP_SHIFT: begin
        if (cmd_r.axis == AXIS_Y) addr_b = cmd_r.flag ? {rz, ry - 3'd1} : {rz, ry + 3'd1};
        else if (cmd_r.axis == AXIS_Z) addr_b = cmd_r.flag ? {rz - 3'd1, ry} : {rz + 3'd1, ry};
      end
      OP_MIRROR: begin
        if (cmd_r.axis == AXIS_Y) addr_b = {rz, ~ry};
        else if (cmd_r.axis == AXIS_Z) addr_b = {~rz, ry};
      end
      default: addr_b = dp_cmd.idx;
    endcase
  end

  // Compute stage works on the registered rows of the previous cycle.
  assign sz = idx_d_r[5:3];
  assign sy = idx_d_r[2:0];
  assign old_row = row_a_r;
  assign src_row = row_b_r;
  assign in_y = (sy >= yl) && (sy <= yh);
  assign in_z = (sz >= zl) && (sz <= zh);
  assign by = (sy == yl) || (sy == yh);
  assign bz = (sz == zl) || (sz == zh);
  assign vbit = 8'd1 << cmd_r.x_a;

  // New value of one swept row, per command.
  always_comb begin
    new_row = old_row;
    unique case (cmd_r.op)
      OP_SET_PLANE, OP_CLR_PLANE: begin
        if (cmd_r.axis == AXIS_X) begin
          new_row = (cmd_r.op == OP_SET_PLANE) ? (old_row | (8'd1 << cmd_r.plane_index))
                                              : (old_row & ~(8'd1 << cmd_r.plane_index));
        end else if ((cmd_r.axis == AXIS_Y && sy == cmd_r.plane_index) ||
                     (cmd_r.axis == AXIS_Z && sz == cmd_r.plane_index)) begin
          new_row = (cmd_r.op == OP_SET_PLANE) ? 8'hff : 8'h00;
        end
      end
      OP_SHIFT: begin
        if (cmd_r.axis == AXIS_X) begin
          new_row = cmd_r.flag ? {old_row[6:0], 1'b0} : {1'b0, old_row[7:1]};
        end else if (cmd_r.axis == AXIS_Y) begin
          new_row = ((cmd_r.flag && sy == 3'd0) || (!cmd_r.flag && sy == 3'd7))
                    ? 8'h00 : src_row;
        end else if (cmd_r.axis == AXIS_Z) begin
          new_row = ((cmd_r.flag && sz == 3'd0) || (!cmd_r.flag && sz == 3'd7))
                    ? 8'h00 : src_row;
        end
      end
      OP_MIRROR: begin
        if (cmd_r.axis == AXIS_X) new_row = reverse8(old_row);
        else if (cmd_r.axis == AXIS_Y || cmd_r.axis == AXIS_Z) new_row = src_row;
      end
      OP_FILL: new_row = cmd_r.pattern;
      OP_BOX_FILLED: if (in_y && in_z) new_row = old_row | run;
      OP_BOX_WALLS: begin
        if (in_y && in_z) new_row = (by || bz) ? run : (old_row | ends);
      end
      OP_BOX_WIRE: begin
        if (by && bz) new_row = run | ends;
        else if ((bz && in_y) || (by && in_z)) new_row = old_row | ends;
      end
      default: new_row = old_row;
    endcase
  end

  // Frame, scratch, read stage and result registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r <= cmd_in;
      voxel_r <= 1'b0;
      rej_r <= (cmd_in.op > OP_BOX_WIRE);
    end
    row_a_r <= frame_r[addr_a];
    row_b_r <= frame_r[addr_b];
    tmp_q_r <= tmp_r[dp_cmd.idx];
    idx_d_r <= dp_cmd.idx;
    if (!rst_n) begin
      single_d_r <= 1'b0;
      sweep_d_r <= 1'b0;
      commit_d_r <= 1'b0;
    end else begin
      single_d_r <= dp_cmd.single;
      sweep_d_r <= dp_cmd.sweep;
      commit_d_r <= dp_cmd.commit;
    end
    if (dp_cmd.clear) begin
      frame_r[dp_cmd.idx] <= 8'h00;
    end else if (single_d_r) begin
      unique case (cmd_r.op)
        OP_WRITE: frame_r[{cmd_r.z_a, cmd_r.y_a}] <=
                    cmd_r.flag ? (old_row | vbit) : (old_row & ~vbit);
        OP_FLIP:  frame_r[{cmd_r.z_a, cmd_r.y_a}] <= old_row ^ vbit;
        default:  voxel_r <= |(old_row & vbit);
      endcase
    end else if (commit_d_r) begin
      frame_r[idx_d_r] <= tmp_q_r;
    end
    if (sweep_d_r) tmp_r[idx_d_r] <= new_row;
  end

  assign res.voxel_on = voxel_r;
  assign res.rejected = rej_r;
endmodule
`default_nettype wire

/* design/vcde_ctrl.sv */
`default_nettype none
module vcde_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        in_op,
  input  wire logic [1:0]        in_axis,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vcde_pkg::dp_cmd_t      dp_cmd
);
  import vcde_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SINGLE, S_SWEEP, S_COMMIT, S_FLUSH, S_DONE
  } state_t;
  state_t state_r;
  logic [5:0] idx_r;
  logic accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    dp_cmd.load = accept;
    dp_cmd.clear = (state_r == S_CLEAR);
    dp_cmd.single = (state_r == S_SINGLE);
    dp_cmd.sweep = (state_r == S_SWEEP);
    dp_cmd.commit = (state_r == S_COMMIT);
    dp_cmd.idx = idx_r;
  end

  // Sequencer: a clearing pass of 64 rows after reset; voxel ops read one row and
  // write it back or sample it; frame ops sweep 64 rows then commit 64, others go
  // straight to done; the flush cycle lets the last registered read reach its write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(RowCount - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          idx_r <= '0;
          if (in_op == OP_WRITE || in_op == OP_FLIP || in_op == OP_READ) state_r <= S_SINGLE;
          else if (in_op > OP_BOX_WIRE) state_r <= S_DONE;
          else if ((in_op == OP_SET_PLANE || in_op == OP_CLR_PLANE || in_op == OP_SHIFT ||
                    in_op == OP_MIRROR) && in_axis == AXIS_NONE) state_r <= S_DONE;
          else state_r <= S_SWEEP;
        end
        S_SINGLE: state_r <= S_FLUSH;
        S_SWEEP: begin
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(RowCount - 1)) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(RowCount - 1)) state_r <= S_FLUSH;
        end
        S_FLUSH: state_r <= S_DONE;
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
